// ===== rtl/cmi_pkg.sv =====
package cmi_pkg;

   localparam int MESH_SIZE_DEFAULT  = 32;
   localparam int VALUE_BITS_DEFAULT = 24;

   localparam int POS_W       = 24;
   localparam int FRAC_W      = 16;
   localparam int CELL_ADDR_W = 15;
   localparam int FIELD_W     = 24;
   localparam int MAX_W       = 23;

   // per-axis weight is 65536-f or f, so one bit above the fraction
   localparam int WGT_W   = FRAC_W + 1;
   localparam int WXY_W   = 2 * WGT_W;
   // product of three axis weights is at most 2^48
   localparam int WPROD_W = 3 * FRAC_W + 1;
   localparam int WLO_W   = 24;
   localparam int WHI_W   = WPROD_W - WLO_W;
   localparam int RND_SH  = 3 * FRAC_W;

   localparam int CORNER_W = 3;
   localparam logic [CORNER_W-1:0] CORNER_LAST = '1;

   localparam logic signed [FIELD_W-1:0] OUT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] OUT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                load_we;
      logic                capture;
      logic                setup;
      logic                issue;
      logic [CORNER_W-1:0] corner;
      logic                sum;
      logic                finish;
   } dp_ctrl_type;

   typedef struct packed {
      logic acc_last;
   } dp_status_type;

endpackage

// ===== rtl/cic_mesh_interpolation.sv =====
// Query: the result strobe follows SETUP, ISSUE, DRAIN, SUM and ROUND; a new query can start
//   with it. Eight corner reads go one per cycle through the single-port mesh memories,
//   then three multiply stages and one wide rounding add finish the sum.
// Load: written at the start edge, busy stays low, one load every cycle while idle.
// Reset clears the controller, strobe and running maximum; mesh contents are kept and
//   are undefined until loaded. The receiver cannot stall: each result shows for one cycle.
module cic_mesh_interpolation #(
   parameter int MESH_SIZE  = cmi_pkg::MESH_SIZE_DEFAULT,
   parameter int VALUE_BITS = cmi_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [cmi_pkg::CELL_ADDR_W-1:0]    req_cell_address,
   input  logic signed [cmi_pkg::FIELD_W-1:0] req_disp_value,
   input  logic signed [cmi_pkg::FIELD_W-1:0] req_vel_value,
   input  logic [cmi_pkg::POS_W-1:0]          req_position_x,
   input  logic [cmi_pkg::POS_W-1:0]          req_position_y,
   input  logic [cmi_pkg::POS_W-1:0]          req_position_z,
   output logic                               rsp_strobe,
   output logic signed [cmi_pkg::FIELD_W-1:0] rsp_displacement,
   output logic signed [cmi_pkg::FIELD_W-1:0] rsp_velocity,
   output logic [cmi_pkg::MAX_W-1:0]          rsp_max_displacement
);
   import cmi_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   cmi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .ctrl       (ctrl),
      .status     (status)
   );

   cmi_datapath #(
      .MESH_SIZE  (MESH_SIZE),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_cell_address     (req_cell_address),
      .req_disp_value       (req_disp_value),
      .req_vel_value        (req_vel_value),
      .req_position_x       (req_position_x),
      .req_position_y       (req_position_y),
      .req_position_z       (req_position_z),
      .ctrl                 (ctrl),
      .status               (status),
      .rsp_displacement     (rsp_displacement),
      .rsp_velocity         (rsp_velocity),
      .rsp_max_displacement (rsp_max_displacement)
   );

endmodule

// ===== rtl/cmi_axis.sv =====
module cmi_axis #(
   parameter int MESH_SIZE = cmi_pkg::MESH_SIZE_DEFAULT
) (
   input  logic [cmi_pkg::POS_W-1:0]   position,
   output logic [$clog2(MESH_SIZE)-1:0] base_index,
   output logic [$clog2(MESH_SIZE)-1:0] next_index,
   output logic [cmi_pkg::WGT_W-1:0]    base_weight,
   output logic [cmi_pkg::WGT_W-1:0]    next_weight
);
   import cmi_pkg::*;

   localparam int NB  = $clog2(MESH_SIZE + 1);
   localparam int IB  = $clog2(MESH_SIZE);
   localparam int U_W = POS_W + NB;

   logic [U_W-1:0]    scaled;
   logic [NB-1:0]     whole;
   logic [FRAC_W-1:0] frac;

   always_comb begin
      scaled = U_W'(position) * U_W'(MESH_SIZE);
      whole  = scaled[U_W-1:POS_W];
      frac   = scaled[POS_W-1:POS_W-FRAC_W];
      if (whole >= NB'(MESH_SIZE)) begin
         base_index = IB'(MESH_SIZE - 1);
      end else begin
         base_index = whole[IB-1:0];
      end
      // periodic box: the +1 neighbor of the last cell is cell 0
      if (base_index == IB'(MESH_SIZE - 1)) begin
         next_index = '0;
      end else begin
         next_index = base_index + 1'b1;
      end
      base_weight = (WGT_W'(1) << FRAC_W) - WGT_W'(frac);
      next_weight = WGT_W'(frac);
   end

endmodule

// ===== rtl/cmi_datapath.sv =====
module cmi_datapath #(
   parameter int MESH_SIZE  = cmi_pkg::MESH_SIZE_DEFAULT,
   parameter int VALUE_BITS = cmi_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cmi_pkg::CELL_ADDR_W-1:0]     req_cell_address,
   input  logic signed [cmi_pkg::FIELD_W-1:0]  req_disp_value,
   input  logic signed [cmi_pkg::FIELD_W-1:0]  req_vel_value,
   input  logic [cmi_pkg::POS_W-1:0]           req_position_x,
   input  logic [cmi_pkg::POS_W-1:0]           req_position_y,
   input  logic [cmi_pkg::POS_W-1:0]           req_position_z,
   input  cmi_pkg::dp_ctrl_type                ctrl,
   output cmi_pkg::dp_status_type              status,
   output logic signed [cmi_pkg::FIELD_W-1:0]  rsp_displacement,
   output logic signed [cmi_pkg::FIELD_W-1:0]  rsp_velocity,
   output logic [cmi_pkg::MAX_W-1:0]           rsp_max_displacement
);
   import cmi_pkg::*;

   localparam int IB        = $clog2(MESH_SIZE);
   localparam int CELLS     = MESH_SIZE * MESH_SIZE * MESH_SIZE;
   localparam int IDX_W     = $clog2(CELLS);
   localparam int MEM_DEPTH = (CELLS > 2 ** CELL_ADDR_W) ? 2 ** CELL_ADDR_W : CELLS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int PL_W      = VALUE_BITS + WLO_W + 1;
   localparam int PH_W      = VALUE_BITS + WHI_W + 1;
   localparam int AL_W      = PL_W + CORNER_W;
   localparam int AH_W      = PH_W + CORNER_W;
   localparam int SUM_W     = AH_W + WLO_W + 1;
   localparam int RES_W     = SUM_W - RND_SH;

   // mesh storage, contents undefined until loaded
   logic signed [VALUE_BITS-1:0] disp_mem [MEM_DEPTH];
   logic signed [VALUE_BITS-1:0] vel_mem  [MEM_DEPTH];

   logic                         load_we;
   logic [ADDR_W-1:0]            wr_addr;
   logic signed [VALUE_BITS-1:0] disp_store;
   logic signed [VALUE_BITS-1:0] vel_store;
   logic [IDX_W-1:0]             cell_sum;
   logic [ADDR_W-1:0]            rd_addr;

   logic [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;

   logic [IB-1:0]    x_base, x_next, y_base, y_next, z_base, z_next;
   logic [WGT_W-1:0] x_w0, x_w1, y_w0, y_w1, z_w0, z_w1;

   logic [1:0][IDX_W-1:0] xt_ff, xt_in, yt_ff, yt_in, zt_ff, zt_in;
   logic [1:0][WGT_W-1:0] wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;

   logic                         s1_valid_ff, s1_valid_in, s1_last_ff, s1_last_in;
   logic [WXY_W-1:0]             wxy_ff, wxy_in;
   logic [WGT_W-1:0]             wz_sel_ff, wz_sel_in;
   logic signed [VALUE_BITS-1:0] disp_rd_ff, vel_rd_ff;

   logic                         s2_valid_ff, s2_last_ff;
   logic [WPROD_W-1:0]           w_ff, w_in;
   logic signed [VALUE_BITS-1:0] dv2_ff, vv2_ff;

   logic                   s3_valid_ff, s3_last_ff;
   logic signed [PL_W-1:0] pd_dlo_ff, pd_dlo_in, pd_vlo_ff, pd_vlo_in;
   logic signed [PH_W-1:0] pd_dhi_ff, pd_dhi_in, pd_vhi_ff, pd_vhi_in;

   logic signed [AL_W-1:0] acc_dlo_ff, acc_dlo_in, acc_vlo_ff, acc_vlo_in;
   logic signed [AH_W-1:0] acc_dhi_ff, acc_dhi_in, acc_vhi_ff, acc_vhi_in;

   logic signed [SUM_W-1:0] sum_d_ff, sum_d_in, sum_v_ff, sum_v_in;

   logic signed [FIELD_W-1:0] disp_res, vel_res;
   logic signed [FIELD_W-1:0] rsp_disp_ff, rsp_vel_ff;
   logic [MAX_W-1:0]          max_ff, max_in;

   function automatic logic signed [FIELD_W-1:0] clamp_out(input logic signed [RES_W-1:0] v);
      logic signed [63:0] wide;
      wide = 64'(v);
      if (wide > 64'(OUT_MAX)) begin
         wide = 64'(OUT_MAX);
      end else if (wide < 64'(OUT_MIN)) begin
         wide = 64'(OUT_MIN);
      end
      return wide[FIELD_W-1:0];
   endfunction

   cmi_axis #(.MESH_SIZE(MESH_SIZE)) u_axis_x (
      .position    (pos_x_ff),
      .base_index  (x_base),
      .next_index  (x_next),
      .base_weight (x_w0),
      .next_weight (x_w1)
   );

   cmi_axis #(.MESH_SIZE(MESH_SIZE)) u_axis_y (
      .position    (pos_y_ff),
      .base_index  (y_base),
      .next_index  (y_next),
      .base_weight (y_w0),
      .next_weight (y_w1)
   );

   cmi_axis #(.MESH_SIZE(MESH_SIZE)) u_axis_z (
      .position    (pos_z_ff),
      .base_index  (z_base),
      .next_index  (z_next),
      .base_weight (z_w0),
      .next_weight (z_w1)
   );

   // load path: out-of-range cells are dropped
   always_comb begin
      load_we    = ctrl.load_we && (32'(req_cell_address) < 32'(CELLS));
      wr_addr    = ADDR_W'(req_cell_address);
      disp_store = VALUE_BITS'(req_disp_value);
      vel_store  = VALUE_BITS'(req_vel_value);
   end

   // per-axis address terms and weights
   always_comb begin
      xt_in[0] = IDX_W'(x_base) * IDX_W'(MESH_SIZE * MESH_SIZE);
      xt_in[1] = IDX_W'(x_next) * IDX_W'(MESH_SIZE * MESH_SIZE);
      yt_in[0] = IDX_W'(y_base) * IDX_W'(MESH_SIZE);
      yt_in[1] = IDX_W'(y_next) * IDX_W'(MESH_SIZE);
      zt_in[0] = IDX_W'(z_base);
      zt_in[1] = IDX_W'(z_next);
      wx_in[0] = x_w0;
      wx_in[1] = x_w1;
      wy_in[0] = y_w0;
      wy_in[1] = y_w1;
      wz_in[0] = z_w0;
      wz_in[1] = z_w1;
   end

   // corner issue: corner bit 2 selects x, bit 1 y, bit 0 z
   always_comb begin
      cell_sum    = xt_ff[ctrl.corner[2]] + yt_ff[ctrl.corner[1]] + zt_ff[ctrl.corner[0]];
      rd_addr     = cell_sum[ADDR_W-1:0];
      s1_valid_in = ctrl.issue;
      s1_last_in  = ctrl.issue && (ctrl.corner == CORNER_LAST);
      wxy_in      = WXY_W'(wx_ff[ctrl.corner[2]]) * WXY_W'(wy_ff[ctrl.corner[1]]);
      wz_sel_in   = wz_ff[ctrl.corner[0]];
   end

   always_comb begin
      w_in      = WPROD_W'((WXY_W + WGT_W)'(wxy_ff) * (WXY_W + WGT_W)'(wz_sel_ff));
      pd_dlo_in = PL_W'(dv2_ff) * PL_W'($signed({1'b0, w_ff[WLO_W-1:0]}));
      pd_vlo_in = PL_W'(vv2_ff) * PL_W'($signed({1'b0, w_ff[WLO_W-1:0]}));
      pd_dhi_in = PH_W'(dv2_ff) * PH_W'($signed({1'b0, w_ff[WPROD_W-1:WLO_W]}));
      pd_vhi_in = PH_W'(vv2_ff) * PH_W'($signed({1'b0, w_ff[WPROD_W-1:WLO_W]}));
   end

   always_comb begin
      acc_dlo_in = acc_dlo_ff;
      acc_dhi_in = acc_dhi_ff;
      acc_vlo_in = acc_vlo_ff;
      acc_vhi_in = acc_vhi_ff;
      if (ctrl.setup) begin
         acc_dlo_in = '0;
         acc_dhi_in = '0;
         acc_vlo_in = '0;
         acc_vhi_in = '0;
      end else if (s3_valid_ff) begin
         acc_dlo_in = acc_dlo_ff + AL_W'(pd_dlo_ff);
         acc_dhi_in = acc_dhi_ff + AH_W'(pd_dhi_ff);
         acc_vlo_in = acc_vlo_ff + AL_W'(pd_vlo_ff);
         acc_vhi_in = acc_vhi_ff + AH_W'(pd_vhi_ff);
      end
   end

   // exact sum plus half an LSB of the 2^48 scale, floor on the shift
   always_comb begin
      sum_d_in = (SUM_W'(acc_dhi_ff) <<< WLO_W) + SUM_W'(acc_dlo_ff)
               + (SUM_W'(1) <<< (RND_SH - 1));
      sum_v_in = (SUM_W'(acc_vhi_ff) <<< WLO_W) + SUM_W'(acc_vlo_ff)
               + (SUM_W'(1) <<< (RND_SH - 1));
   end

   always_comb begin
      disp_res = clamp_out($signed(sum_d_ff[SUM_W-1:RND_SH]));
      vel_res  = clamp_out($signed(sum_v_ff[SUM_W-1:RND_SH]));
      max_in   = max_ff;
      if (disp_res > $signed({1'b0, max_ff})) begin
         max_in = disp_res[MAX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         disp_mem[wr_addr] <= disp_store;
         vel_mem[wr_addr]  <= vel_store;
      end
      if (ctrl.issue) begin
         disp_rd_ff <= disp_mem[rd_addr];
         vel_rd_ff  <= vel_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         pos_x_ff <= req_position_x;
         pos_y_ff <= req_position_y;
         pos_z_ff <= req_position_z;
      end
      if (ctrl.setup) begin
         xt_ff <= xt_in;
         yt_ff <= yt_in;
         zt_ff <= zt_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         wz_ff <= wz_in;
      end
      wxy_ff     <= wxy_in;
      wz_sel_ff  <= wz_sel_in;
      w_ff       <= w_in;
      dv2_ff     <= disp_rd_ff;
      vv2_ff     <= vel_rd_ff;
      pd_dlo_ff  <= pd_dlo_in;
      pd_dhi_ff  <= pd_dhi_in;
      pd_vlo_ff  <= pd_vlo_in;
      pd_vhi_ff  <= pd_vhi_in;
      acc_dlo_ff <= acc_dlo_in;
      acc_dhi_ff <= acc_dhi_in;
      acc_vlo_ff <= acc_vlo_in;
      acc_vhi_ff <= acc_vhi_in;
      if (ctrl.sum) begin
         sum_d_ff <= sum_d_in;
         sum_v_ff <= sum_v_in;
      end
      if (ctrl.finish) begin
         rsp_disp_ff <= disp_res;
         rsp_vel_ff  <= vel_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_last_ff  <= 1'b0;
         max_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
         s2_valid_ff <= s1_valid_ff;
         s2_last_ff  <= s1_last_ff;
         s3_valid_ff <= s2_valid_ff;
         s3_last_ff  <= s2_last_ff;
         if (ctrl.finish) begin
            max_ff <= max_in;
         end
      end
   end

   assign status.acc_last      = s3_valid_ff && s3_last_ff;
   assign rsp_displacement     = rsp_disp_ff;
   assign rsp_velocity         = rsp_vel_ff;
   assign rsp_max_displacement = max_ff;

endmodule

// ===== rtl/cmi_ctrl.sv =====
module cmi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_cmd,
   output logic                   busy,
   output logic                   rsp_strobe,
   output cmi_pkg::dp_ctrl_type   ctrl,
   input  cmi_pkg::dp_status_type status
);
   import cmi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_DRAIN,
      ST_SUM,
      ST_ROUND
   } state_type;

   state_type           state_ff, state_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic                strobe_ff, strobe_in;
   logic                accept;

   always_comb begin
      busy   = (state_ff != ST_IDLE);
      accept = start && !busy;

      ctrl.load_we = accept && (req_cmd == CMD_LOAD);
      ctrl.capture = accept && (req_cmd == CMD_QUERY);
      ctrl.setup   = (state_ff == ST_SETUP);
      ctrl.issue   = (state_ff == ST_ISSUE);
      ctrl.corner  = corner_ff;
      ctrl.sum     = (state_ff == ST_SUM);
      ctrl.finish  = (state_ff == ST_ROUND);

      state_in  = state_ff;
      corner_in = corner_ff;
      strobe_in = (state_ff == ST_ROUND);
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.capture) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in  = ST_ISSUE;
            corner_in = '0;
         end
         ST_ISSUE: begin
            corner_in = corner_ff + 1'b1;
            if (corner_ff == CORNER_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.acc_last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         corner_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a transaction is still in progress");

   a_strobe_round: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_ROUND)
      else $error("result strobe not preceded by the rounding step");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_QUERY) |=> busy)
      else $error("query transaction accepted but controller stayed idle");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_LOAD) |=> !busy)
      else $error("load transaction made the controller busy");

   a_acc_drain: assert property (@(posedge clock) disable iff (reset)
      status.acc_last |-> state_ff == ST_DRAIN)
      else $error("last corner reached the accumulator outside the drain phase");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cmi_pkg::*;

   localparam int MESH         = MESH_SIZE_DEFAULT;
   localparam int VBITS        = VALUE_BITS_DEFAULT;
   localparam int CELLS        = MESH * MESH * MESH;
   localparam int AXIS_STEP    = (1 << POS_W) / MESH;
   localparam int RANDOM_ITEMS = 900;
   localparam int LONG_GAP     = 40;
   localparam int QUERY_CYCLES = 15;

   typedef struct {
      cmd_type                   cmd;
      logic [CELL_ADDR_W-1:0]    cell_address;
      logic signed [FIELD_W-1:0] disp_value;
      logic signed [FIELD_W-1:0] vel_value;
      logic [POS_W-1:0]          pos_x;
      logic [POS_W-1:0]          pos_y;
      logic [POS_W-1:0]          pos_z;
      int                        gap;
      bit                        drain;
   } mesh_txn_type;

   typedef struct {
      logic signed [FIELD_W-1:0] displacement;
      logic signed [FIELD_W-1:0] velocity;
      logic [MAX_W-1:0]          max_displacement;
   } readout_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = 1'b0;
   logic [CELL_ADDR_W-1:0]    req_cell_address = '0;
   logic signed [FIELD_W-1:0] req_disp_value = '0;
   logic signed [FIELD_W-1:0] req_vel_value = '0;
   logic [POS_W-1:0]          req_position_x = '0;
   logic [POS_W-1:0]          req_position_y = '0;
   logic [POS_W-1:0]          req_position_z = '0;
   logic                      rsp_strobe;
   logic signed [FIELD_W-1:0] rsp_displacement;
   logic signed [FIELD_W-1:0] rsp_velocity;
   logic [MAX_W-1:0]          rsp_max_displacement;

   cic_mesh_interpolation #(
      .MESH_SIZE  (MESH),
      .VALUE_BITS (VBITS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_cmd              (req_cmd),
      .req_cell_address     (req_cell_address),
      .req_disp_value       (req_disp_value),
      .req_vel_value        (req_vel_value),
      .req_position_x       (req_position_x),
      .req_position_y       (req_position_y),
      .req_position_z       (req_position_z),
      .rsp_strobe           (rsp_strobe),
      .rsp_displacement     (rsp_displacement),
      .rsp_velocity         (rsp_velocity),
      .rsp_max_displacement (rsp_max_displacement)
   );

   mesh_txn_type      backlog[$];
   readout_type       readouts_due[$];
   bit                seeded [CELLS];
   logic signed [31:0] disp_cells [CELLS];
   logic signed [31:0] vel_cells [CELLS];
   logic [MAX_W-1:0]  peak = '0;

   mesh_txn_type head;
   bit        head_loaded = 1'b0;
   int        idle_left = 0;
   int        burst_left = 0;
   int        mismatches = 0;
   int        loads_sent = 0;
   int        queries_sent = 0;
   int        results_seen = 0;
   longint    cycles = 0;
   longint    cycle_limit = 64'd1_000_000;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int cell_of(input int x, input int y, input int z);
      return (x * MESH + y) * MESH + z;
   endfunction

   function automatic int axis_cell(input logic [POS_W-1:0] pos);
      longint unsigned u;
      u = longint'(pos) * MESH;
      return int'(u >> POS_W);
   endfunction

   function automatic int axis_next(input int c);
      return (c + 1 >= MESH) ? 0 : c + 1;
   endfunction

   // sign-extend the load field, then wrap to the stored cell width
   function automatic logic signed [31:0] to_stored(input logic signed [FIELD_W-1:0] v);
      logic signed [31:0] x;
      x = v;
      x = (x <<< (32 - VBITS)) >>> (32 - VBITS);
      return x;
   endfunction

   // divide by 2^48, nearest with ties up, then saturate to the output field
   function automatic logic signed [FIELD_W-1:0] round_clamp(input logic signed [95:0] acc);
      logic signed [95:0] r;
      r = (acc + 96'sh8000_0000_0000) >>> RND_SH;
      if (r > OUT_MAX) return OUT_MAX;
      if (r < OUT_MIN) return OUT_MIN;
      return r[FIELD_W-1:0];
   endfunction

   task automatic apply_transaction(input mesh_txn_type t);
      logic [POS_W-1:0]    pos [3];
      int                  base [3];
      int                  nxt [3];
      longint unsigned     wt [3][2];
      longint unsigned     u;
      longint unsigned     f;
      longint unsigned     w;
      logic signed [95:0]  acc_d;
      logic signed [95:0]  acc_v;
      logic signed [95:0]  ww;
      int                  a;
      int                  idx;
      readout_type         r;
      if (t.cmd == CMD_LOAD) begin
         if (int'(t.cell_address) < CELLS) begin
            disp_cells[t.cell_address] = to_stored(t.disp_value);
            vel_cells[t.cell_address]  = to_stored(t.vel_value);
         end
         loads_sent++;
         return;
      end
      pos[0] = t.pos_x;
      pos[1] = t.pos_y;
      pos[2] = t.pos_z;
      for (a = 0; a < 3; a++) begin
         u = longint'(pos[a]) * MESH;
         base[a] = int'(u >> POS_W);
         f = (u >> (POS_W - FRAC_W)) & 64'hFFFF;
         nxt[a] = axis_next(base[a]);
         wt[a][0] = 64'd65536 - f;
         wt[a][1] = f;
      end
      acc_d = '0;
      acc_v = '0;
      // corner bit 2 picks the x neighbor, bit 1 y, bit 0 z
      for (a = 0; a < 8; a++) begin
         idx = cell_of(a[2] ? nxt[0] : base[0], a[1] ? nxt[1] : base[1],
                       a[0] ? nxt[2] : base[2]);
         w = wt[0][a[2]] * wt[1][a[1]] * wt[2][a[0]];
         ww = w;
         acc_d += disp_cells[idx] * ww;
         acc_v += vel_cells[idx] * ww;
      end
      r.displacement = round_clamp(acc_d);
      r.velocity     = round_clamp(acc_v);
      if (r.displacement > $signed({1'b0, peak}))
         peak = r.displacement[MAX_W-1:0];
      r.max_displacement = peak;
      readouts_due.push_back(r);
      queries_sent++;
   endtask

   function automatic logic signed [FIELD_W-1:0] rand_value(input longint cap);
      logic signed [FIELD_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = OUT_MIN;
         1: v = FIELD_W'(cap);
         2: begin
            v = FIELD_W'($urandom_range(0, 511));
            v = v - FIELD_W'(256);
         end
         default: v = FIELD_W'($urandom);
      endcase
      if (!v[FIELD_W-1] && longint'(v) > cap)
         v = FIELD_W'(longint'(v) % (cap + 1));
      return v;
   endfunction

   function automatic logic [POS_W-1:0] pick_axis();
      int c;
      int frac;
      case ($urandom_range(0, 9))
         0, 1: c = 0;
         2: c = 1;
         3: c = MESH - 2;
         4, 5: c = MESH - 1;
         default: c = $urandom_range(0, MESH - 1);
      endcase
      case ($urandom_range(0, 7))
         0: frac = 0;
         1: frac = AXIS_STEP - 1;
         2: frac = AXIS_STEP / 2;
         default: frac = $urandom_range(0, AXIS_STEP - 1);
      endcase
      return POS_W'(c * AXIS_STEP + frac);
   endfunction

   task automatic enqueue(input mesh_txn_type t);
      if (burst_left > 0) begin
         t.gap = 0;
         burst_left--;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               burst_left = $urandom_range(20, 60);
               t.gap = 0;
            end
            1, 2: t.gap = $urandom_range(8, LONG_GAP);
            3, 4, 5, 6, 7, 8: t.gap = $urandom_range(1, 3);
            default: t.gap = 0;
         endcase
      end
      if (t.cmd == CMD_LOAD && int'(t.cell_address) < CELLS)
         seeded[t.cell_address] = 1'b1;
      backlog.push_back(t);
   endtask

   task automatic push_load(input int addr, input logic signed [FIELD_W-1:0] d,
                            input logic signed [FIELD_W-1:0] v);
      mesh_txn_type t;
      t.cmd          = CMD_LOAD;
      t.cell_address = CELL_ADDR_W'(addr);
      t.disp_value   = d;
      t.vel_value    = v;
      t.pos_x        = POS_W'($urandom);
      t.pos_y        = POS_W'($urandom);
      t.pos_z        = POS_W'($urandom);
      t.gap          = 0;
      t.drain        = 1'b0;
      enqueue(t);
   endtask

   task automatic push_query(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic [POS_W-1:0] z, input bit drain);
      mesh_txn_type t;
      t.cmd          = CMD_QUERY;
      t.cell_address = CELL_ADDR_W'($urandom);
      t.disp_value   = FIELD_W'($urandom);
      t.vel_value    = FIELD_W'($urandom);
      t.pos_x        = x;
      t.pos_y        = y;
      t.pos_z        = z;
      t.gap          = 0;
      t.drain        = drain;
      enqueue(t);
   endtask

   // load whatever corners are still blank, maybe rewrite one, then query
   task automatic plan_query(input longint cap, input bit drain);
      logic [POS_W-1:0] p [3];
      int               base [3];
      int               nxt [3];
      int               a;
      int               addr;
      for (a = 0; a < 3; a++) begin
         p[a]    = pick_axis();
         base[a] = axis_cell(p[a]);
         nxt[a]  = axis_next(base[a]);
      end
      for (a = 0; a < 8; a++) begin
         addr = cell_of(a[2] ? nxt[0] : base[0], a[1] ? nxt[1] : base[1],
                        a[0] ? nxt[2] : base[2]);
         if (!seeded[addr])
            push_load(addr, rand_value(cap), rand_value(longint'(OUT_MAX)));
      end
      if ($urandom_range(0, 3) == 0) begin
         a = $urandom_range(0, 7);
         addr = cell_of(a[2] ? nxt[0] : base[0], a[1] ? nxt[1] : base[1],
                        a[0] ? nxt[2] : base[2]);
         push_load(addr, rand_value(cap), rand_value(longint'(OUT_MAX)));
      end
      push_query(p[0], p[1], p[2], drain);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            apply_transaction(head);
            head_loaded = 1'b0;
         end
         if (!head_loaded && backlog.size() != 0) begin
            head        = backlog.pop_front();
            head_loaded = 1'b1;
            idle_left   = head.gap;
         end
         if (head_loaded && idle_left == 0 && !(head.drain && readouts_due.size() != 0)) begin
            start            <= 1'b1;
            req_cmd          <= head.cmd;
            req_cell_address <= head.cell_address;
            req_disp_value   <= head.disp_value;
            req_vel_value    <= head.vel_value;
            req_position_x   <= head.pos_x;
            req_position_y   <= head.pos_y;
            req_position_z   <= head.pos_z;
         end else begin
            if (idle_left > 0)
               idle_left--;
            start            <= 1'b0;
            req_cmd          <= 1'($urandom_range(0, 1));
            req_cell_address <= CELL_ADDR_W'($urandom);
            req_disp_value   <= FIELD_W'($urandom);
            req_vel_value    <= FIELD_W'($urandom);
            req_position_x   <= POS_W'($urandom);
            req_position_y   <= POS_W'($urandom);
            req_position_z   <= POS_W'($urandom);
         end
      end
   end

   always @(posedge clock) begin : check_results
      readout_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         results_seen++;
         if (readouts_due.size() == 0) begin
            $error("result strobe with no query outstanding");
            mismatches++;
         end else begin
            want = readouts_due.pop_front();
            if (rsp_displacement !== want.displacement) begin
               $error("displacement: expected %0d, got %0d", want.displacement,
                      rsp_displacement);
               mismatches++;
            end
            if (rsp_velocity !== want.velocity) begin
               $error("velocity: expected %0d, got %0d", want.velocity, rsp_velocity);
               mismatches++;
            end
            if (rsp_max_displacement !== want.max_displacement) begin
               $error("max_displacement: expected %0d, got %0d", want.max_displacement,
                      rsp_max_displacement);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > cycle_limit) begin
         $display("cic_mesh_interpolation regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int     a;
      int     directed_count;
      bit     drained;
      longint cap;
      // all-negative displacement block around the far corner, wrapping to zero
      for (a = 0; a < 8; a++)
         push_load(cell_of(a[2] ? 0 : MESH - 1, a[1] ? 0 : MESH - 1, a[0] ? 0 : MESH - 1),
                   OUT_MIN, OUT_MAX);
      push_query(POS_W'(24'hFFFFFF), POS_W'(24'hFFFFFF), POS_W'(24'hFFFFFF), 1'b0);
      push_query(POS_W'((MESH - 1) * AXIS_STEP), POS_W'((MESH - 1) * AXIS_STEP),
                 POS_W'((MESH - 1) * AXIS_STEP), 1'b0);
      // exact half between two cells: rounding ties go up
      push_load(cell_of(MESH - 1, MESH - 1, MESH - 1), FIELD_W'(0), FIELD_W'(-1));
      push_load(cell_of(MESH - 1, MESH - 1, 0), FIELD_W'(1), FIELD_W'(0));
      push_query(POS_W'((MESH - 1) * AXIS_STEP), POS_W'((MESH - 1) * AXIS_STEP),
                 POS_W'((MESH - 1) * AXIS_STEP + AXIS_STEP / 2), 1'b1);
      for (a = 1; a < 8; a++)
         push_load(cell_of(a[2], a[1], a[0]), FIELD_W'(100 * a), a[0] ? OUT_MAX : OUT_MIN);
      push_query('0, '0, '0, 1'b0);
      push_query(POS_W'(AXIS_STEP - 1), POS_W'(AXIS_STEP - 1), POS_W'(AXIS_STEP - 1), 1'b0);
      push_query(POS_W'(AXIS_STEP / 2), '0, POS_W'(AXIS_STEP - 1), 1'b0);
      directed_count = backlog.size();

      drained = 1'b0;
      while (backlog.size() < directed_count + RANDOM_ITEMS) begin
         // positive displacements grow over the run so the running max keeps moving
         cap = (longint'(OUT_MAX) * (backlog.size() - directed_count + 1)) / RANDOM_ITEMS;
         if ($urandom_range(0, 99) < 15) begin
            push_load($urandom_range(0, CELLS - 1), rand_value(cap),
                      rand_value(longint'(OUT_MAX)));
         end else if (!drained && backlog.size() >= directed_count + RANDOM_ITEMS / 2) begin
            plan_query(cap, 1'b1);
            drained = 1'b1;
         end else begin
            plan_query(cap, 1'b0);
         end
      end
      cycle_limit = longint'(backlog.size()) * (QUERY_CYCLES + LONG_GAP + 2) * 4 + 20000;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (backlog.size() != 0 || head_loaded || start || readouts_due.size() != 0)
         @(posedge clock);
      repeat (QUERY_CYCLES * 3) @(posedge clock);

      $display("Covered %0d loads and %0d queries with random gaps, bursts and one drain;",
               loads_sent, queries_sent);
      $display("%0d results checked, %0d mismatches, running max ended at %0d.",
               results_seen, mismatches, peak);
      if (mismatches == 0)
         $display("cic_mesh_interpolation regression: pass");
      else
         $display("cic_mesh_interpolation regression: fail");
      $finish;
   end

endmodule

// ===== cic_mesh_interpolation.f =====
rtl/cmi_pkg.sv
rtl/cmi_axis.sv
rtl/cmi_datapath.sv
rtl/cmi_ctrl.sv
rtl/cic_mesh_interpolation.sv
bench/testbench.sv
